[hw/rtl/ndxf_pkg.sv]
// Shared constants, register indexes and cathode pin tables for the nixie crossfade driver.
`timescale 1ns / 1ps
`default_nettype none
package ndxf_pkg;

	localparam int unsigned DigitW    = 4;
	localparam int unsigned TimeW     = 12;
	localparam int unsigned PhaseW    = 13;
	localparam int unsigned CfgIndexW = 2;

	localparam logic [6:0]       MaxShown     = 7'd99;
	localparam logic [TimeW-1:0] FadeTotalRst = 12'd1200;
	localparam logic [TimeW-1:0] FadeStepRst  = 12'd40;

	localparam logic [CfgIndexW-1:0] REG_FADE_ENABLE = 2'd0;
	localparam logic [CfgIndexW-1:0] REG_FADE_TOTAL  = 2'd1;
	localparam logic [CfgIndexW-1:0] REG_FADE_STEP   = 2'd2;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_NUMBER = 1'b1;

	typedef logic [DigitW-1:0] digit_t;

	typedef struct packed {
		logic [15:0] cathode;
		logic [7:0]  io;
	} drive_t;

	// tens = num / 10 for num up to 99, by reciprocal multiply (205 / 2048)
	function automatic digit_t tens_of(input logic [6:0] num);
		logic [15:0] prod;
		prod = 16'(num) * 16'd205;
		return prod[14:11];
	endfunction

	function automatic digit_t ones_of(input logic [6:0] num, input digit_t tens);
		logic [6:0] t10;
		t10 = 7'(tens) * 7'd10;
		return DigitW'(num - t10);
	endfunction

	function automatic drive_t tens_pins(input digit_t d);
		drive_t r;
		r = '0;
		case (d)
			4'd0: r.cathode = 16'h0040;
			4'd1: r.io      = 8'h20;
			4'd2: r.io      = 8'h40;
			4'd3: r.io      = 8'h80;
			4'd4: r.cathode = 16'h0001;
			4'd5: r.cathode = 16'h0002;
			4'd6: r.cathode = 16'h0004;
			4'd7: r.cathode = 16'h0008;
			4'd8: r.cathode = 16'h0010;
			4'd9: r.cathode = 16'h0020;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic drive_t ones_pins(input digit_t d);
		drive_t r;
		r = '0;
		case (d)
			4'd0: r.cathode = 16'h0200;
			4'd1: r.io      = 8'h04;
			4'd2: r.io      = 8'h02;
			4'd3: r.io      = 8'h01;
			4'd4: r.cathode = 16'h8000;
			4'd5: r.cathode = 16'h4000;
			4'd6: r.cathode = 16'h2000;
			4'd7: r.cathode = 16'h1000;
			4'd8: r.cathode = 16'h0800;
			4'd9: r.cathode = 16'h0400;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/ndxf_drive.sv]
// Digit pair to cathode and io drive word lookup.
`timescale 1ns / 1ps
`default_nettype none
module ndxf_drive
	import ndxf_pkg::*;
(
	input  wire digit_t tens,
	input  wire digit_t ones,
	output drive_t      drive
);

	drive_t tens_d;
	drive_t ones_d;

	assign tens_d = tens_pins(tens);
	assign ones_d = ones_pins(ones);

	// both tubes share the same ports, so OR their pins
	assign drive.cathode = tens_d.cathode | ones_d.cathode;
	assign drive.io      = tens_d.io | ones_d.io;

endmodule
`default_nettype wire

[hw/rtl/two_digit_nixie_crossfade_driver_unit.sv]
// A request's result is formed combinationally and loaded into the output register on acceptance.
// Throughput: one request per cycle when not stalled; next state settles in its accept cycle.
// The input side stays ready while the output register is empty or being drained.
// Reset: display shows "00", no fade running, fade enabled with total 1200 and step 40.
// Configuration writes are taken in every cycle; unknown indexes are dropped.
`timescale 1ns / 1ps
`default_nettype none
module two_digit_nixie_crossfade_driver_unit
	import ndxf_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire                  req_type,
	input  wire  [7:0]           number,
	output logic                 out_valid,
	input  wire                  out_ready,
	output logic [15:0]          cathode_word,
	output logic [7:0]           io_word,
	output logic                 fading,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [CfgIndexW-1:0] cfg_index,
	input  wire  [TimeW-1:0]     cfg_data
);

	logic             fade_enable_q;
	logic [TimeW-1:0] fade_total_q;
	logic [TimeW-1:0] fade_step_q;

	digit_t            old_tens_q, old_ones_q, new_tens_q, new_ones_q;
	logic [TimeW-1:0]  old_time_q;
	logic [PhaseW-1:0] phase_q;
	logic              showing_new_q;
	logic              fade_busy_q;

	digit_t            old_tens_d, old_ones_d, new_tens_d, new_ones_d;
	logic [TimeW-1:0]  old_time_d;
	logic [PhaseW-1:0] phase_d;
	logic              showing_new_d;
	logic              fade_busy_d;

	logic              in_fire;
	logic [6:0]        num_sat;
	digit_t            num_tens, num_ones;
	logic [TimeW-1:0]  step_eff;
	logic [PhaseW-1:0] total_p1, old_time_ext, new_len, phase_inc;
	digit_t            shown_tens, shown_ones;
	logic              res_fading;
	drive_t            res_drive;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_enable_q <= 1'b1;
			fade_total_q  <= FadeTotalRst;
			fade_step_q   <= FadeStepRst;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FADE_ENABLE: fade_enable_q <= cfg_data[0];
				REG_FADE_TOTAL:  fade_total_q  <= cfg_data;
				REG_FADE_STEP:   fade_step_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign num_sat  = (number > 8'(MaxShown)) ? MaxShown : number[6:0];
	assign num_tens = tens_of(num_sat);
	assign num_ones = ones_of(num_sat, num_tens);

	assign step_eff     = (fade_step_q == '0) ? TimeW'(1) : fade_step_q;
	assign total_p1     = PhaseW'(fade_total_q) + PhaseW'(1);
	assign old_time_ext = PhaseW'(old_time_q);
	assign new_len      = (total_p1 > old_time_ext) ? (total_p1 - old_time_ext) : PhaseW'(1);
	assign phase_inc    = phase_q + PhaseW'(1);

	always_comb begin
		old_tens_d    = old_tens_q;
		old_ones_d    = old_ones_q;
		new_tens_d    = new_tens_q;
		new_ones_d    = new_ones_q;
		old_time_d    = old_time_q;
		phase_d       = phase_q;
		showing_new_d = showing_new_q;
		fade_busy_d   = fade_busy_q;
		if (req_type == REQ_NUMBER) begin
			// a running fade ends at once: its target becomes the old digits
			if (fade_busy_q) begin
				old_tens_d = new_tens_q;
				old_ones_d = new_ones_q;
			end
			new_tens_d = num_tens;
			new_ones_d = num_ones;
			phase_d    = '0;
			if (fade_enable_q && fade_total_q != '0) begin
				old_time_d    = fade_total_q;
				showing_new_d = 1'b0;
				fade_busy_d   = 1'b1;
			end else begin
				old_tens_d    = num_tens;
				old_ones_d    = num_ones;
				old_time_d    = '0;
				showing_new_d = 1'b1;
				fade_busy_d   = 1'b0;
			end
		end else if (fade_busy_q) begin
			phase_d = phase_inc;
			if (!showing_new_q) begin
				if (phase_inc >= old_time_ext) begin
					showing_new_d = 1'b1;
					phase_d       = '0;
				end
			end else if (phase_inc >= new_len) begin
				phase_d = '0;
				if (old_time_q <= step_eff) begin
					old_tens_d  = new_tens_q;
					old_ones_d  = new_ones_q;
					old_time_d  = '0;
					fade_busy_d = 1'b0;
				end else begin
					old_time_d    = old_time_q - step_eff;
					showing_new_d = 1'b0;
				end
			end
		end
	end

	// a number shows the state after it is taken in, a tick the state before it advances
	always_comb begin
		if (req_type == REQ_NUMBER) begin
			shown_tens = showing_new_d ? new_tens_d : old_tens_d;
			shown_ones = showing_new_d ? new_ones_d : old_ones_d;
			res_fading = fade_busy_d;
		end else begin
			shown_tens = showing_new_q ? new_tens_q : old_tens_q;
			shown_ones = showing_new_q ? new_ones_q : old_ones_q;
			res_fading = fade_busy_q;
		end
	end

	ndxf_drive u_drive (
		.tens  (shown_tens),
		.ones  (shown_ones),
		.drive (res_drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_tens_q    <= '0;
			old_ones_q    <= '0;
			new_tens_q    <= '0;
			new_ones_q    <= '0;
			old_time_q    <= '0;
			phase_q       <= '0;
			showing_new_q <= 1'b1;
			fade_busy_q   <= 1'b0;
		end else if (in_fire) begin
			old_tens_q    <= old_tens_d;
			old_ones_q    <= old_ones_d;
			new_tens_q    <= new_tens_d;
			new_ones_q    <= new_ones_d;
			old_time_q    <= old_time_d;
			phase_q       <= phase_d;
			showing_new_q <= showing_new_d;
			fade_busy_q   <= fade_busy_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// hold the result while the downstream side stalls
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cathode_word <= res_drive.cathode;
			io_word      <= res_drive.io;
			fading       <= res_fading;
		end
	end

`ifndef ASSERT_OFF
	a_idle_shows_new: assert property (@(posedge clk) disable iff (!arst_n)
		!fade_busy_q |-> (showing_new_q && phase_q == '0 && old_time_q == '0))
		else $error("idle state not settled on new digits");

	a_old_time_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(fade_busy_q && !showing_new_q) |-> (old_time_q != '0))
		else $error("old-digit period of zero length during fade");

	a_number_starts_fade: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req_type == REQ_NUMBER && fade_enable_q && fade_total_q != '0)
		|=> (fade_busy_q && !showing_new_q && fading))
		else $error("number request did not start a fade");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid)
		else $error("accepted request produced no result");
`endif

endmodule
`default_nettype wire

[tb/nixie_drive_checker_pkg.sv]
// Drive-word predictor and result checker for the nixie crossfade driver testbench.
`timescale 1ns / 1ps
package nixie_drive_checker_pkg;
	import ndxf_pkg::*;

	typedef struct packed {
		logic [15:0] cathode;
		logic [7:0]  io;
		logic        fading;
	} drive_word_t;

	localparam logic [15:0] TensOc [10] = '{
		16'h0040, 16'h0000, 16'h0000, 16'h0000, 16'h0001,
		16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0020};
	localparam logic [7:0]  TensIo [10] = '{
		8'h00, 8'h20, 8'h40, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
	localparam logic [15:0] OnesOc [10] = '{
		16'h0200, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
		16'h4000, 16'h2000, 16'h1000, 16'h0800, 16'h0400};
	localparam logic [7:0]  OnesIo [10] = '{
		8'h00, 8'h04, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

	class nixie_drive_checker;
		logic              fade_on;
		logic [TimeW-1:0]  fade_len;
		logic [TimeW-1:0]  fade_dec;
		digit_t            old_tens, old_ones, new_tens, new_ones;
		logic [TimeW-1:0]  old_span;
		logic [PhaseW-1:0] ticks_in_phase;
		logic              on_new;
		logic              in_fade;
		drive_word_t       drive_expected[$];
		int                failures;

		function new();
			fade_on        = 1'b1;
			fade_len       = FadeTotalRst;
			fade_dec       = FadeStepRst;
			old_tens       = '0;
			old_ones       = '0;
			new_tens       = '0;
			new_ones       = '0;
			old_span       = '0;
			ticks_in_phase = '0;
			on_new         = 1'b1;
			in_fade        = 1'b0;
			failures       = 0;
		endfunction

		function int pending();
			return drive_expected.size();
		endfunction

		function void write_reg(logic [CfgIndexW-1:0] idx, logic [TimeW-1:0] data);
			case (idx)
				REG_FADE_ENABLE: fade_on = data[0];
				REG_FADE_TOTAL:  fade_len = data;
				REG_FADE_STEP:   fade_dec = data;
				default: ;
			endcase
		endfunction

		function drive_word_t shown_drive(logic f);
			drive_word_t d;
			digit_t      t, o;
			d = '0;
			t = on_new ? new_tens : old_tens;
			o = on_new ? new_ones : old_ones;
			if (t < 10) begin
				d.cathode |= TensOc[t];
				d.io      |= TensIo[t];
			end
			if (o < 10) begin
				d.cathode |= OnesOc[o];
				d.io      |= OnesIo[o];
			end
			d.fading = f;
			return d;
		endfunction

		function void end_fade();
			old_tens       = new_tens;
			old_ones       = new_ones;
			on_new         = 1'b1;
			in_fade        = 1'b0;
			ticks_in_phase = '0;
			old_span       = '0;
		endfunction

		function void advance_tick();
			logic [TimeW-1:0] dec;
			int               new_span;
			dec = (fade_dec == '0) ? 12'd1 : fade_dec;
			if (!in_fade)
				return;
			ticks_in_phase = ticks_in_phase + 1'b1;
			if (!on_new) begin
				if (ticks_in_phase >= old_span) begin
					on_new         = 1'b1;
					ticks_in_phase = '0;
				end
				return;
			end
			// shrunk total leaves a single-tick new period
			new_span = (int'(fade_len) + 1 > int'(old_span)) ?
				int'(fade_len) + 1 - int'(old_span) : 1;
			if (int'(ticks_in_phase) >= new_span) begin
				ticks_in_phase = '0;
				if (old_span <= dec)
					end_fade();
				else begin
					old_span = old_span - dec;
					on_new   = 1'b0;
				end
			end
		endfunction

		function void take_number(logic [7:0] num);
			int n;
			n = (num > MaxShown) ? int'(MaxShown) : int'(num);
			if (in_fade)
				end_fade();
			new_tens = digit_t'(n / 10);
			new_ones = digit_t'(n % 10);
			if (fade_on && fade_len != '0) begin
				old_span       = fade_len;
				ticks_in_phase = '0;
				on_new         = 1'b0;
				in_fade        = 1'b1;
			end else
				end_fade();
		endfunction

		function void note_request(logic rt, logic [7:0] num);
			if (rt == REQ_NUMBER) begin
				take_number(num);
				drive_expected.push_back(shown_drive(in_fade));
			end else begin
				drive_expected.push_back(shown_drive(in_fade));
				advance_tick();
			end
		endfunction

		function void check_result(logic [15:0] c, logic [7:0] i, logic f);
			drive_word_t e;
			if (drive_expected.size() == 0) begin
				$error("result with no request pending: cathode_word %h io_word %h fading %b",
					c, i, f);
				failures++;
				return;
			end
			e = drive_expected.pop_front();
			if (c !== e.cathode) begin
				$error("cathode_word: expected %h, got %h", e.cathode, c);
				failures++;
			end
			if (i !== e.io) begin
				$error("io_word: expected %h, got %h", e.io, i);
				failures++;
			end
			if (f !== e.fading) begin
				$error("fading: expected %b, got %b", e.fading, f);
				failures++;
			end
		endfunction
	endclass

endpackage

[tb/testbench.sv]
// Top-level testbench for the two-digit nixie crossfade driver.
`timescale 1ns / 1ps
module testbench;
	import ndxf_pkg::*;
	import nixie_drive_checker_pkg::*;

	localparam int CycleLimit = 100000;
	localparam int HoldCycles = 200;
	localparam int HoldAfter  = 500;
	localparam int PhaseItems = 120;
	localparam logic [CfgIndexW-1:0] RegUnused = 2'd3;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic                 req_type  = REQ_TICK;
	logic [7:0]           number    = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [15:0]          cathode_word;
	logic [7:0]           io_word;
	logic                 fading;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [TimeW-1:0]     cfg_data  = '0;

	logic steady       = 1'b0;
	int   cycles       = 0;
	int   results_seen = 0;
	int   hold_left    = 0;
	bit   held         = 1'b0;

	nixie_drive_checker drive_chk;

	always #6 clk = ~clk;

	two_digit_nixie_crossfade_driver_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.number       (number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cathode_word (cathode_word),
		.io_word      (io_word),
		.fading       (fading),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			drive_chk.check_result(cathode_word, io_word, fading);
			results_seen++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held && results_seen >= HoldAfter) begin
			held      = 1'b1;
			hold_left = HoldCycles;
			out_ready <= 1'b0;
		end else
			out_ready <= steady || ($urandom_range(0, 99) >= 8);
	end

	task automatic send_request(input logic rt, input logic [7:0] num);
		if (!steady) begin
			while ($urandom_range(0, 99) < 8) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		req_type <= rt;
		number   <= num;
		do @(posedge clk); while (!in_ready);
		drive_chk.note_request(rt, num);
	endtask

	// hold input, let every result out, then allow the pipeline to settle
	task automatic drain();
		in_valid <= 1'b0;
		while (drive_chk.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [TimeW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		drive_chk.write_reg(idx, data);
	endtask

	task automatic configure(input logic en, input logic [TimeW-1:0] total,
			input logic [TimeW-1:0] step);
		drain();
		write_reg(REG_FADE_ENABLE, {{(TimeW-1){1'b0}}, en});
		write_reg(REG_FADE_TOTAL, total);
		write_reg(REG_FADE_STEP, step);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_ticks(input int n);
		for (int k = 0; k < n; k++)
			send_request(REQ_TICK, 8'($urandom));
	endtask

	task automatic random_phase(input int count, input int number_pct);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < number_pct)
				send_request(REQ_NUMBER, 8'($urandom_range(0, 255)));
			else
				send_request(REQ_TICK, 8'($urandom));
		end
	endtask

	initial begin
		logic             en;
		logic [TimeW-1:0] tot, stp;
		int               pct;
		drive_chk = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown index must be dropped
		write_reg(RegUnused, 12'hFFF);
		cfg_valid <= 1'b0;

		// reset display, saturation, number during fade
		send_request(REQ_TICK, 8'h00);
		send_request(REQ_NUMBER, 8'd0);
		send_request(REQ_TICK, 8'hFF);
		send_request(REQ_NUMBER, 8'd99);
		send_request(REQ_NUMBER, 8'd100);
		send_request(REQ_NUMBER, 8'd255);
		send_request(REQ_NUMBER, 8'h55);
		send_request(REQ_TICK, 8'hAA);

		// fading off switches at once
		configure(1'b0, 12'd1200, 12'd40);
		send_request(REQ_NUMBER, 8'd37);
		send_request(REQ_TICK, 8'h00);

		// zero total behaves as fading off
		configure(1'b1, 12'd0, 12'd0);
		send_request(REQ_NUMBER, 8'd42);

		// zero step counts as one: a full short fade
		configure(1'b1, 12'd2, 12'd0);
		send_request(REQ_NUMBER, 8'd5);
		send_ticks(7);

		// shrink the total below the old-digit time mid-fade
		configure(1'b1, 12'd4, 12'd1);
		send_request(REQ_NUMBER, 8'd68);
		send_ticks(9);
		drain();
		write_reg(REG_FADE_TOTAL, 12'd1);
		cfg_valid <= 1'b0;
		send_ticks(3);

		for (int p = 0; p < 14; p++) begin
			case (p)
				0: begin
					en  = 1'b0;
					tot = 12'($urandom);
					stp = 12'($urandom);
					pct = 30;
				end
				1: begin
					en  = 1'b1;
					tot = 12'hFFF;
					stp = 12'hFFF;
					pct = 2;
				end
				2: begin
					en  = 1'b1;
					tot = 12'd1;
					stp = 12'd1;
					pct = 10;
				end
				3: begin
					en  = 1'b1;
					tot = 12'd0;
					stp = 12'($urandom);
					pct = 20;
				end
				4: begin
					en  = 1'b1;
					tot = 12'($urandom_range(1, 4095));
					stp = 12'd0;
					pct = 3;
				end
				5: begin
					en  = 1'b1;
					tot = 12'hFFF;
					stp = 12'd1;
					pct = 2;
				end
				default: begin
					en  = ($urandom_range(0, 9) != 0);
					tot = 12'($urandom_range(1, 24));
					stp = 12'($urandom_range(0, 8));
					pct = $urandom_range(2, 8);
				end
			endcase
			configure(en, tot, stp);
			if (p == 7)
				steady <= 1'b1;
			random_phase(PhaseItems, pct);
			if (p == 7)
				steady <= 1'b0;
		end

		drain();
		repeat (4) @(posedge clk);
		if (drive_chk.failures == 0 && drive_chk.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
